/* design/mecanum_wheel_mix_limit_assert.svh */
// ----------------------------------------------------------------------------
// mecanum wheel mixer assertion macros
// concurrent checks that vanish when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef MECANUM_WHEEL_MIX_LIMIT_ASSERT_SVH
`define MECANUM_WHEEL_MIX_LIMIT_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define MWML_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mwml check failed: same cycle");

// next-cycle implication
`define MWML_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mwml check failed: next cycle");

`else

`define MWML_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define MWML_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* design/mwml_pkg.sv */
// ----------------------------------------------------------------------------
// mwml_pkg
// widths, register indexes and pipeline types of the mecanum wheel mixer
// ----------------------------------------------------------------------------
package mwml_pkg;

   localparam int SPD_W      = 16;                 // Q8.8 speed / set-point
   localparam int ARM_W      = 16;                 // Q4.12 arm length
   localparam int LIM_W      = 15;                 // unsigned Q7.8 speed limit
   localparam int ROT_W      = SPD_W + ARM_W + 1;  // arm * wz product
   localparam int ROT_SHIFT  = 12;                 // Q12.20 back to Q8.8
   localparam int WHL_W      = ROT_W - ROT_SHIFT;  // full width wheel sum
   localparam int MAG_W      = WHL_W - 1;          // wheel magnitude
   localparam int NUM_W      = MAG_W + LIM_W;      // magnitude * limit
   localparam int QUO_W      = LIM_W;              // scaled magnitude
   localparam int DIV_STEPS  = QUO_W;              // one quotient bit per stage
   localparam int NUM_WHEELS = 4;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] REG_ARM_LENGTH        = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_WHEEL_SPEED_LIMIT = 1'b1;

   localparam logic [ARM_W-1:0] ARM_LENGTH_RST = 16'd819;
   localparam logic [LIM_W-1:0] SPEED_LIMIT_RST = 15'd1024;

   typedef struct packed {
      logic             neg;
      logic [SPD_W-1:0] raw;
      logic [NUM_W-1:0] rem;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   typedef struct packed {
      logic                              vld;
      logic                              scaled;
      logic [MAG_W-1:0]                  den;
      div_lane_type [NUM_WHEELS-1:0]     lane;
   } div_stage_type;

endpackage

/* design/mecanum_wheel_mix_limit.sv */
// ----------------------------------------------------------------------------
// mecanum_wheel_mix_limit
// mecanum inverse kinematics with proportional wheel speed limiting
// ----------------------------------------------------------------------------
// req_* carries one chassis set-point (vx, vy, wz, signed Q8.8) per
// transaction; rsp_* returns the four wheel speeds and a was_scaled flag in
// tuser. csr_* writes arm_length (index 0) and wheel_speed_limit (index 1);
// write them only while no transaction is in flight.
// An accepted transaction reaches rsp_tvalid through 22 register
// stages: six stages of product, rounding, mixing, magnitude, maximum and
// numerator, fifteen restoring divide stages that each settle one quotient
// bit of |w| * limit / max for all four wheels, and the output register.
// Throughput is one transaction per cycle while rsp_tready does not stall the pipeline.
// Reset clears every stage valid bit and loads the registers with
// arm_length 819 and wheel_speed_limit 1024. When the receiver holds
// rsp_tready low with a result waiting, the whole pipeline freezes and
// req_tready drops in the same cycle; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "mecanum_wheel_mix_limit_assert.svh"

module mecanum_wheel_mix_limit
   import mwml_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [47:0]           req_tdata,   // vx, vy, wz
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata,   // wheel0..wheel3 speed
   output logic                  rsp_tuser,   // was_scaled
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [ARM_W-1:0] arm_length_ff;
   logic [LIM_W-1:0] speed_limit_ff;
   logic             pipe_en;

   // stage 1: rotation product
   logic             s1_vld_ff;
   logic [SPD_W-1:0] s1_vx_ff, s1_vy_ff;
   logic [ROT_W-1:0] s1_rot_ff, s1_rot_in;
   // stage 2: rotation term back in Q8.8
   logic             s2_vld_ff;
   logic [SPD_W-1:0] s2_vx_ff, s2_vy_ff;
   logic [WHL_W-1:0] s2_rot_ff;
   logic [ROT_W-1:0] rot_sum;
   // stage 3: wheel sums
   logic             s3_vld_ff;
   logic [WHL_W-1:0] s3_whl_ff [NUM_WHEELS];
   logic [WHL_W-1:0] s3_whl_in [NUM_WHEELS];
   // stage 4: magnitudes
   logic             s4_vld_ff;
   logic [MAG_W-1:0] s4_mag_ff [NUM_WHEELS];
   logic             s4_neg_ff [NUM_WHEELS];
   logic [SPD_W-1:0] s4_raw_ff [NUM_WHEELS];
   // stage 5: maximum and limit compare
   logic             s5_vld_ff, s5_scaled_ff;
   logic [MAG_W-1:0] s5_den_ff;
   logic [MAG_W-1:0] s5_mag_ff [NUM_WHEELS];
   logic             s5_neg_ff [NUM_WHEELS];
   logic [SPD_W-1:0] s5_raw_ff [NUM_WHEELS];
   logic [MAG_W-1:0] max01, max23, max_all;
   // divider stages; entry 0 holds the numerator
   div_stage_type    d_ff [DIV_STEPS+1];
   div_stage_type    d_in [DIV_STEPS+1];
   logic [NUM_W:0]   d_sub [DIV_STEPS][NUM_WHEELS];
   // output register
   logic             rsp_vld_ff;
   logic [63:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_scaled_ff;

   assign pipe_en    = ~rsp_vld_ff | rsp_tready;
   assign req_tready = pipe_en;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_scaled_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         arm_length_ff  <= ARM_LENGTH_RST;
         speed_limit_ff <= SPEED_LIMIT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_ARM_LENGTH:        arm_length_ff  <= csr_wdata[ARM_W-1:0];
            REG_WHEEL_SPEED_LIMIT: speed_limit_ff <= csr_wdata[LIM_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [ROT_W-1:0] wz_ext, arm_ext;
      logic [WHL_W-1:0] vx_ext, vy_ext;
      wz_ext    = {{(ROT_W-SPD_W){req_tdata[47]}}, req_tdata[47:32]};
      arm_ext   = {{(ROT_W-ARM_W){1'b0}}, arm_length_ff};
      s1_rot_in = ROT_W'($signed(wz_ext) * $signed(arm_ext));

      // truncate toward zero: bias negative products before the shift
      rot_sum = s1_rot_ff + (s1_rot_ff[ROT_W-1] ?
                             ROT_W'((1 << ROT_SHIFT) - 1) : ROT_W'(0));

      vx_ext = {{(WHL_W-SPD_W){s2_vx_ff[SPD_W-1]}}, s2_vx_ff};
      vy_ext = {{(WHL_W-SPD_W){s2_vy_ff[SPD_W-1]}}, s2_vy_ff};
      s3_whl_in[0] = vy_ext - vx_ext - s2_rot_ff;
      s3_whl_in[1] = WHL_W'(0) - vx_ext - vy_ext - s2_rot_ff;
      s3_whl_in[2] = vx_ext + vy_ext - s2_rot_ff;
      s3_whl_in[3] = vx_ext - vy_ext - s2_rot_ff;

      max01   = (s4_mag_ff[0] > s4_mag_ff[1]) ? s4_mag_ff[0] : s4_mag_ff[1];
      max23   = (s4_mag_ff[2] > s4_mag_ff[3]) ? s4_mag_ff[2] : s4_mag_ff[3];
      max_all = (max01 > max23) ? max01 : max23;
   end

   // numerator entry and restoring divide steps
   always_comb begin
      d_in[0].vld    = s5_vld_ff;
      d_in[0].scaled = s5_scaled_ff;
      d_in[0].den    = s5_den_ff;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         d_in[0].lane[l].neg = s5_neg_ff[l];
         d_in[0].lane[l].raw = s5_raw_ff[l];
         d_in[0].lane[l].rem = NUM_W'(s5_mag_ff[l]) * NUM_W'(speed_limit_ff);
         d_in[0].lane[l].quo = '0;
      end
      for (int s = 0; s < DIV_STEPS; s++) begin
         d_in[s+1].vld    = d_ff[s].vld;
         d_in[s+1].scaled = d_ff[s].scaled;
         d_in[s+1].den    = d_ff[s].den;
         for (int l = 0; l < NUM_WHEELS; l++) begin
            d_sub[s][l] = {1'b0, d_ff[s].lane[l].rem}
                        - ((NUM_W+1)'(d_ff[s].den) << (DIV_STEPS - 1 - s));
            d_in[s+1].lane[l].neg = d_ff[s].lane[l].neg;
            d_in[s+1].lane[l].raw = d_ff[s].lane[l].raw;
            d_in[s+1].lane[l].rem = d_sub[s][l][NUM_W] ? d_ff[s].lane[l].rem
                                                        : d_sub[s][l][NUM_W-1:0];
            d_in[s+1].lane[l].quo = {d_ff[s].lane[l].quo[QUO_W-2:0],
                                     ~d_sub[s][l][NUM_W]};
         end
      end
   end

   always_comb begin
      logic [SPD_W-1:0] q_ext;
      for (int l = 0; l < NUM_WHEELS; l++) begin
         q_ext = {{(SPD_W-QUO_W){1'b0}}, d_ff[DIV_STEPS].lane[l].quo};
         if (d_ff[DIV_STEPS].scaled) begin
            rsp_data_in[l*SPD_W +: SPD_W] = d_ff[DIV_STEPS].lane[l].neg ?
                                            SPD_W'(0) - q_ext : q_ext;
         end else begin
            rsp_data_in[l*SPD_W +: SPD_W] = d_ff[DIV_STEPS].lane[l].raw;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         s3_vld_ff  <= 1'b0;
         s4_vld_ff  <= 1'b0;
         s5_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int s = 0; s <= DIV_STEPS; s++) begin
            d_ff[s].vld <= 1'b0;
         end
      end else if (pipe_en) begin
         s1_vld_ff <= req_tvalid;
         s1_vx_ff  <= req_tdata[15:0];
         s1_vy_ff  <= req_tdata[31:16];
         s1_rot_ff <= s1_rot_in;

         s2_vld_ff <= s1_vld_ff;
         s2_vx_ff  <= s1_vx_ff;
         s2_vy_ff  <= s1_vy_ff;
         s2_rot_ff <= rot_sum[ROT_W-1:ROT_SHIFT];

         s3_vld_ff <= s2_vld_ff;
         s3_whl_ff <= s3_whl_in;

         s4_vld_ff <= s3_vld_ff;
         for (int l = 0; l < NUM_WHEELS; l++) begin
            s4_neg_ff[l] <= s3_whl_ff[l][WHL_W-1];
            s4_raw_ff[l] <= s3_whl_ff[l][SPD_W-1:0];
            s4_mag_ff[l] <= s3_whl_ff[l][WHL_W-1] ?
                            MAG_W'(WHL_W'(0) - s3_whl_ff[l]) : s3_whl_ff[l][MAG_W-1:0];
         end

         s5_vld_ff    <= s4_vld_ff;
         s5_den_ff    <= max_all;
         s5_scaled_ff <= max_all > MAG_W'(speed_limit_ff);
         s5_mag_ff    <= s4_mag_ff;
         s5_neg_ff    <= s4_neg_ff;
         s5_raw_ff    <= s4_raw_ff;

         d_ff <= d_in;

         rsp_vld_ff    <= d_ff[DIV_STEPS].vld;
         rsp_data_ff   <= rsp_data_in;
         rsp_scaled_ff <= d_ff[DIV_STEPS].scaled;
      end
   end

   // an empty output slot never holds back the input side
   `MWML_ASSERT_NOW(a_ready_when_empty, clock, reset, !rsp_tvalid, req_tready)
   // an accepted transaction always lands in the first stage
   `MWML_ASSERT_NEXT(a_accept_lands, clock, reset, req_tvalid && req_tready, s1_vld_ff)
   // wheel 0's quotient fits: its numerator is below max shifted by the quotient width
   `MWML_ASSERT_NOW(a_div_range, clock, reset, d_ff[0].vld && d_ff[0].scaled,
      d_ff[0].lane[0].rem < ({15'd0, d_ff[0].den} << QUO_W))
   // a scaled wheel 0 never exceeds the limit
   `MWML_ASSERT_NOW(a_quo_limit, clock, reset,
      d_ff[DIV_STEPS].vld && d_ff[DIV_STEPS].scaled,
      d_ff[DIV_STEPS].lane[0].quo <= speed_limit_ff)

endmodule
